[sv/rgct_pkg.sv]
// Shared types, constants and helpers for the ray grid cell traversal block.
// Depends on nothing; used by every other file in this folder.
package rgct_pkg;

	localparam int FRAC_BITS          = 16;
	localparam int MAX_CELLS_PER_AXIS = 16;
	localparam int MAX_RESULTS        = 3 * MAX_CELLS_PER_AXIS - 2;
	localparam int K_W                = $clog2(MAX_RESULTS);
	localparam int DIV_N_W            = 64;
	localparam int DIV_D_W            = 34;
	localparam int DIV_C_W            = $clog2(DIV_N_W);

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	// divider job kinds
	localparam logic [1:0] K_TMIN  = 2'd0;
	localparam logic [1:0] K_TMAX  = 2'd1;
	localparam logic [1:0] K_DELTA = 2'd2;
	localparam logic [1:0] K_CELL  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_MIN_X = 3'd0;
	localparam logic [2:0] CFG_MIN_Y = 3'd1;
	localparam logic [2:0] CFG_MIN_Z = 3'd2;
	localparam logic [2:0] CFG_MAX_X = 3'd3;
	localparam logic [2:0] CFG_MAX_Y = 3'd4;
	localparam logic [2:0] CFG_MAX_Z = 3'd5;
	localparam logic [2:0] CFG_CELLS = 3'd6;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic [11:0]        cell_index;
		logic signed [31:0] t_limit;
		logic               missed;
		logic               last;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       slab_inf;
		logic       div_start;
		logic       div_wr;
		logic [1:0] kind;
		logic [1:0] axis;
		logic       latch_t0;
		logic       mul;
		logic       pnt;
		logic       num;
		logic       cell_zero;
		logic       next_init;
		logic       walk;
		logic       force_last;
		logic       emit_miss;
	} cmd_t;

	typedef struct packed {
		logic       pre_miss;
		logic [2:0] dir_zero;
		logic       range_miss;
		logic       div_done;
		logic       num_neg;
		logic       walk_last;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return T_MAX;
		end else if (v < -64'sd2147483648) begin
			return T_MIN;
		end
		return v[31:0];
	endfunction

	// cell count for one axis from the packed count-minus-one field
	function automatic logic [4:0] n_of(input logic [11:0] cpa, input logic [1:0] a);
		logic [3:0] f;
		case (a)
			2'd0:    f = cpa[3:0];
			2'd1:    f = cpa[7:4];
			default: f = cpa[11:8];
		endcase
		return {1'b0, f} + 5'd1;
	endfunction

endpackage

[sv/rgct_div.sv]
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on rgct_pkg for widths.
module rgct_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rgct_pkg::DIV_N_W-1:0]  dividend,
	input  logic [rgct_pkg::DIV_D_W-1:0]  divisor,
	output logic                          done,
	output logic [rgct_pkg::DIV_N_W-1:0]  quotient
);

	logic                            run_q;
	logic                            done_q;
	logic [rgct_pkg::DIV_C_W-1:0]    cnt_q;
	logic [rgct_pkg::DIV_D_W-1:0]    rem_q;
	logic [rgct_pkg::DIV_D_W-1:0]    dsr_q;
	logic [rgct_pkg::DIV_N_W-1:0]    quo_q;
	logic [rgct_pkg::DIV_D_W:0]      trial;
	logic                            fits;

	assign trial = {rem_q, quo_q[rgct_pkg::DIV_N_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rgct_pkg::DIV_C_W'(rgct_pkg::DIV_N_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? rgct_pkg::DIV_D_W'(trial - {1'b0, dsr_q})
			              : trial[rgct_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[rgct_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/rgct_dp.sv]
// Datapath: configuration, ray registers, slab/entry setup and the DDA walk.
// Depends on rgct_pkg and rgct_div; driven by rgct_ctrl commands.
module rgct_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  rgct_pkg::ray_t    ray,
	input  rgct_pkg::cmd_t    cmd,
	output rgct_pkg::sts_t    sts,
	output logic              result_valid,
	output rgct_pkg::result_t result
);

	logic signed [31:0] gmin_q [3];
	logic signed [31:0] gmax_q [3];
	logic [11:0]        cpa_q;

	logic signed [31:0] o_q   [3];
	logic signed [31:0] d_q   [3];
	logic signed [31:0] tlo_q [3];
	logic signed [31:0] thi_q [3];
	logic signed [31:0] nt_q  [3];
	logic [32:0]        dl_q  [3];
	logic [3:0]         cc_q  [3];
	logic signed [31:0] t0_q;
	logic               in_box_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] pm_q;
	logic signed [55:0] num_q;
	logic               neg_q;
	logic               out_v_q;
	rgct_pkg::result_t  out_q;

	logic [1:0]                       ax;
	logic [4:0]                       n_a;
	logic signed [31:0]               bound;
	logic signed [32:0]               diff;
	logic [32:0]                      nmag;
	logic [32:0]                      dmag;
	logic                             dneg;
	logic [rgct_pkg::DIV_N_W-1:0]     dvd;
	logic [rgct_pkg::DIV_D_W-1:0]     dvs;
	logic                             div_done;
	logic [rgct_pkg::DIV_N_W-1:0]     q;
	logic signed [31:0]               qsat;
	logic [4:0]                       nm1;
	logic [3:0]                       qcell;
	logic signed [31:0]               t0;
	logic signed [31:0]               t1;
	logic                             in_box;
	logic [4:0]                       mfac;
	logic [37:0]                      mprod;
	logic signed [31:0]               nt_init;
	logic [1:0]                       sel;
	logic [4:0]                       n_s;
	logic                             s_zero;
	logic                             s_pos;
	logic                             step_last;
	logic                             walk_last;
	logic [4:0]                       n0;
	logic [4:0]                       n1;
	logic [12:0]                      idx;
	logic [2:0]                       pre;

	assign ax  = cmd.axis;
	assign n_a = rgct_pkg::n_of(cpa_q, ax);
	assign n0  = rgct_pkg::n_of(cpa_q, 2'd0);
	assign n1  = rgct_pkg::n_of(cpa_q, 2'd1);

	// slab divide operands
	assign dneg  = d_q[ax][31];
	assign bound = ((cmd.kind == rgct_pkg::K_TMIN) != dneg) ? gmin_q[ax] : gmax_q[ax];
	assign diff  = {bound[31], bound} - {o_q[ax][31], o_q[ax]};
	assign nmag  = diff[32] ? 33'(-diff) : 33'(diff);
	assign dmag  = dneg ? 33'(-{d_q[ax][31], d_q[ax]}) : {1'b0, d_q[ax]};

	always_comb begin
		case (cmd.kind)
			rgct_pkg::K_DELTA: begin
				dvd = rgct_pkg::DIV_N_W'(33'({thi_q[ax][31], thi_q[ax]}
				      - {tlo_q[ax][31], tlo_q[ax]}));
				dvs = rgct_pkg::DIV_D_W'(n_a);
			end
			rgct_pkg::K_CELL: begin
				dvd = rgct_pkg::DIV_N_W'(num_q[54:0]);
				dvs = rgct_pkg::DIV_D_W'(33'({gmax_q[ax][31], gmax_q[ax]}
				      - {gmin_q[ax][31], gmin_q[ax]}));
			end
			default: begin
				dvd = rgct_pkg::DIV_N_W'({nmag, {rgct_pkg::FRAC_BITS{1'b0}}});
				dvs = rgct_pkg::DIV_D_W'(dmag);
			end
		endcase
	end

	rgct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (q)
	);

	always_comb begin
		if (!neg_q) begin
			qsat = (q > 64'h7FFF_FFFF) ? rgct_pkg::T_MAX : q[31:0];
		end else begin
			qsat = (q > 64'h8000_0000) ? rgct_pkg::T_MIN : 32'(~q[31:0] + 32'd1);
		end
	end

	assign nm1   = n_a - 5'd1;
	assign qcell = (q > 64'(nm1)) ? nm1[3:0] : q[3:0];

	// slab intersection and in-box test
	always_comb begin
		t0     = tlo_q[0];
		t1     = thi_q[0];
		in_box = 1'b1;
		for (int a = 1; a < 3; a++) begin
			if (tlo_q[a] > t0) t0 = tlo_q[a];
			if (thi_q[a] < t1) t1 = thi_q[a];
		end
		for (int a = 0; a < 3; a++) begin
			if (!(o_q[a] > gmin_q[a] && o_q[a] < gmax_q[a])) in_box = 1'b0;
			pre[a] = (gmax_q[a] <= gmin_q[a]) ||
			         (d_q[a] == 32'sd0 && (o_q[a] < gmin_q[a] || o_q[a] > gmax_q[a]));
		end
	end

	// first boundary parameter on the entry axis
	assign mfac    = dneg ? (n_a - {1'b0, cc_q[ax]}) : ({1'b0, cc_q[ax]} + 5'd1);
	assign mprod   = 38'(mfac) * 38'(dl_q[ax]);
	assign nt_init = rgct_pkg::sat32(64'(tlo_q[ax]) + $signed({26'd0, mprod}));

	// walk step
	always_comb begin
		if (nt_q[0] < nt_q[1] && nt_q[0] < nt_q[2]) sel = 2'd0;
		else if (nt_q[1] < nt_q[2])                sel = 2'd1;
		else                                       sel = 2'd2;
	end

	assign n_s       = rgct_pkg::n_of(cpa_q, sel);
	assign s_zero    = d_q[sel] == 32'sd0;
	assign s_pos     = !d_q[sel][31];
	assign step_last = s_zero || (s_pos && {1'b0, cc_q[sel]} == n_s - 5'd1) ||
	                   (!s_pos && cc_q[sel] == 4'd0);
	assign walk_last = step_last || cmd.force_last;
	assign idx       = 13'(cc_q[0]) + 13'(n0) * 13'(cc_q[1])
	                   + 13'(n0) * 13'(n1) * 13'(cc_q[2]);

	assign sts.pre_miss   = |pre;
	assign sts.dir_zero   = {d_q[2] == 32'sd0, d_q[1] == 32'sd0, d_q[0] == 32'sd0};
	assign sts.range_miss = t0 > t1;
	assign sts.div_done   = div_done;
	assign sts.num_neg    = num_q[55];
	assign sts.walk_last  = walk_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				gmin_q[a] <= 32'sd0;
				gmax_q[a] <= 32'sd65536;
			end
			cpa_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					rgct_pkg::CFG_MIN_X: gmin_q[0] <= cfg_data;
					rgct_pkg::CFG_MIN_Y: gmin_q[1] <= cfg_data;
					rgct_pkg::CFG_MIN_Z: gmin_q[2] <= cfg_data;
					rgct_pkg::CFG_MAX_X: gmax_q[0] <= cfg_data;
					rgct_pkg::CFG_MAX_Y: gmax_q[1] <= cfg_data;
					rgct_pkg::CFG_MAX_Z: gmax_q[2] <= cfg_data;
					rgct_pkg::CFG_CELLS: cpa_q     <= cfg_data[11:0];
					default: ;
				endcase
			end
			out_v_q <= cmd.walk || cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			o_q[0] <= ray.origin_x;
			o_q[1] <= ray.origin_y;
			o_q[2] <= ray.origin_z;
			d_q[0] <= ray.dir_x;
			d_q[1] <= ray.dir_y;
			d_q[2] <= ray.dir_z;
		end
		if (cmd.slab_inf) begin
			tlo_q[ax] <= rgct_pkg::T_MIN;
			thi_q[ax] <= rgct_pkg::T_MAX;
		end
		if (cmd.div_start) begin
			neg_q <= diff[32] ^ dneg;
		end
		if (cmd.div_wr) begin
			case (cmd.kind)
				rgct_pkg::K_TMIN:  tlo_q[ax] <= qsat;
				rgct_pkg::K_TMAX:  thi_q[ax] <= qsat;
				rgct_pkg::K_DELTA: dl_q[ax]  <= q[32:0];
				default:           cc_q[ax]  <= qcell;
			endcase
		end
		if (cmd.latch_t0) begin
			t0_q     <= t0;
			in_box_q <= in_box;
		end
		if (cmd.mul) begin
			prod_q <= 64'(t0_q) * 64'(d_q[ax]);
		end
		if (cmd.pnt) begin
			pm_q <= (in_box_q ? 50'(o_q[ax])
			                  : 50'(o_q[ax]) + 50'(prod_q >>> rgct_pkg::FRAC_BITS))
			        - 50'(gmin_q[ax]);
		end
		if (cmd.num) begin
			num_q <= 56'(pm_q) * 56'($signed({1'b0, n_a}));
		end
		if (cmd.cell_zero) begin
			cc_q[ax] <= 4'd0;
		end
		if (cmd.next_init) begin
			nt_q[ax] <= (d_q[ax] == 32'sd0) ? rgct_pkg::T_MAX : nt_init;
		end
		if (cmd.walk && !s_zero) begin
			cc_q[sel] <= s_pos ? cc_q[sel] + 4'd1 : cc_q[sel] - 4'd1;
			nt_q[sel] <= rgct_pkg::sat32(64'(nt_q[sel]) + $signed({31'd0, dl_q[sel]}));
		end
		if (cmd.walk) begin
			out_q.cell_index <= idx[11:0];
			out_q.t_limit    <= nt_q[sel];
			out_q.missed     <= 1'b0;
			out_q.last       <= walk_last;
		end else if (cmd.emit_miss) begin
			out_q.cell_index <= '0;
			out_q.t_limit    <= '0;
			out_q.missed     <= 1'b1;
			out_q.last       <= 1'b1;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

[sv/rgct_ctrl.sv]
// Controller: sequences slab divides, per-axis entry setup and the walk.
// Depends on rgct_pkg; issues commands to rgct_dp.
module rgct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rgct_pkg::sts_t sts,
	output rgct_pkg::cmd_t cmd,
	output logic           busy
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_CHECK      = 4'd1;
	localparam logic [3:0] S_SLAB_GO    = 4'd2;
	localparam logic [3:0] S_SLAB_WAIT  = 4'd3;
	localparam logic [3:0] S_RANGE      = 4'd4;
	localparam logic [3:0] S_MUL        = 4'd5;
	localparam logic [3:0] S_PNT        = 4'd6;
	localparam logic [3:0] S_NUM        = 4'd7;
	localparam logic [3:0] S_CELL_GO    = 4'd8;
	localparam logic [3:0] S_CELL_WAIT  = 4'd9;
	localparam logic [3:0] S_DELTA_GO   = 4'd10;
	localparam logic [3:0] S_DELTA_WAIT = 4'd11;
	localparam logic [3:0] S_NEXT       = 4'd12;
	localparam logic [3:0] S_WALK       = 4'd13;
	localparam logic [3:0] S_MISS       = 4'd14;

	logic [3:0]                 state_q;
	logic [3:0]                 state_d;
	logic [1:0]                 axis_q;
	logic [1:0]                 axis_d;
	logic                       half_q;
	logic                       half_d;
	logic [rgct_pkg::K_W-1:0]   k_q;
	logic [rgct_pkg::K_W-1:0]   k_d;

	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		cmd.kind = half_q ? rgct_pkg::K_TMAX : rgct_pkg::K_TMIN;
		state_d  = state_q;
		axis_d   = axis_q;
		half_d   = half_q;
		k_d      = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				axis_d  = 2'd0;
				half_d  = 1'b0;
				state_d = sts.pre_miss ? S_MISS : S_SLAB_GO;
			end
			S_SLAB_GO: begin
				if (sts.dir_zero[axis_q]) begin
					cmd.slab_inf = 1'b1;
					if (axis_q == 2'd2) state_d = S_RANGE;
					else axis_d = axis_q + 2'd1;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_SLAB_WAIT;
				end
			end
			S_SLAB_WAIT: begin
				if (sts.div_done) begin
					cmd.div_wr = 1'b1;
					half_d     = !half_q;
					state_d    = S_SLAB_GO;
					if (half_q) begin
						if (axis_q == 2'd2) state_d = S_RANGE;
						else axis_d = axis_q + 2'd1;
					end
				end
			end
			S_RANGE: begin
				cmd.latch_t0 = 1'b1;
				axis_d       = 2'd0;
				state_d      = sts.range_miss ? S_MISS : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_PNT;
			end
			S_PNT: begin
				cmd.pnt = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_d = S_CELL_GO;
			end
			S_CELL_GO: begin
				cmd.kind = rgct_pkg::K_CELL;
				if (sts.num_neg) begin
					cmd.cell_zero = 1'b1;
					state_d       = S_DELTA_GO;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_CELL_WAIT;
				end
			end
			S_CELL_WAIT: begin
				cmd.kind = rgct_pkg::K_CELL;
				if (sts.div_done) begin
					cmd.div_wr = 1'b1;
					state_d    = S_DELTA_GO;
				end
			end
			S_DELTA_GO: begin
				cmd.kind      = rgct_pkg::K_DELTA;
				cmd.div_start = 1'b1;
				state_d       = S_DELTA_WAIT;
			end
			S_DELTA_WAIT: begin
				cmd.kind = rgct_pkg::K_DELTA;
				if (sts.div_done) begin
					cmd.div_wr = 1'b1;
					state_d    = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.next_init = 1'b1;
				if (axis_q == 2'd2) begin
					k_d     = '0;
					state_d = S_WALK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_WALK: begin
				cmd.walk       = 1'b1;
				cmd.force_last = k_q == rgct_pkg::K_W'(rgct_pkg::MAX_RESULTS - 1);
				k_d            = k_q + 1'b1;
				if (sts.walk_last) state_d = S_IDLE;
			end
			S_MISS: begin
				cmd.emit_miss = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			half_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			half_q  <= half_d;
			k_q     <= k_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

[sv/ray_grid_cell_traversal.sv]
// Ray / uniform grid traversal (3D DDA): one ray in, visited cells out.
// Up to twelve divides (six slab, three entry cell, three delta) share one
// radix-2 divider; the walk then gives one cell per cycle, at most 46.
// One ray at a time; busy is high until the last result is registered.
// Async reset clears control and loads the default box; results cannot stall.
module ray_grid_cell_traversal (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rgct_pkg::ray_t    ray,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              result_valid,
	output rgct_pkg::result_t result
);

	rgct_pkg::cmd_t cmd;
	rgct_pkg::sts_t sts;

	rgct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rgct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ray          (ray),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
